/* design/plp_pkg.sv */
// ----------------------------------------------------------------------------
// plp_pkg
// Shared codes and types for the positional linked list block.
// ----------------------------------------------------------------------------
package plp_pkg;

    localparam int FUNC_W = 2;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    // Operation codes carried by func.
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Strobes from the sequencer to the node store.
    typedef struct packed {
        logic link_rd;
        logic link_wr;
        logic val_rd;
        logic val_wr;
    } plp_mem_ctl_t;

endpackage

/* design/positional_linked_list.sv */
// ----------------------------------------------------------------------------
// positional_linked_list
// Singly linked list in a fixed node store, addressed by 1-based position.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): func selects insert, delete or read,
// position is the 1-based list position, value is the data to insert.
// Output channel (out_valid/out_ready): one result per item with status
// (done, position out of range, store full), value_out (value read or
// removed, zero otherwise) and count (entries after the operation).
// Items are processed one at a time. A read, a middle insert or a delete
// past the head walks links from the head, one hop per cycle through the
// registered read port of the link memory; a delete at the head, an append
// and an insert at the head or into an empty list need no walk, and a
// rejected item goes straight to its result. in_ready is high only while
// the sequencer is idle, in the cycle after each result leaves it. A result
// sits in an output register, so the next item is accepted while it waits;
// a stalled receiver holds the sequencer once its next result is ready.
// Reset empties the list at once: no clearing pass is needed, since
// never-used nodes are tracked by a fill mark.
// ----------------------------------------------------------------------------
module positional_linked_list
    import plp_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [FUNC_W-1:0]       func,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [STAT_W-1:0]       status,
    output logic signed [VAL_W-1:0] value_out,
    output logic [CNT_W-1:0]        count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = $clog2(CAPACITY + 1);

    plp_mem_ctl_t          mem_ctl;
    logic [AW-1:0]         link_raddr, link_waddr, val_raddr, val_waddr;
    logic [IW-1:0]         link_wdata, link_q;
    logic [DATA_WIDTH-1:0] val_wdata, val_q;

    logic              res_valid, res_ready;
    logic [STAT_W-1:0] res_status;
    logic [VAL_W-1:0]  res_value;
    logic [CNT_W-1:0]  res_count;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] status_reg;
    logic [VAL_W-1:0]  value_out_reg;
    logic [CNT_W-1:0]  count_reg;

    plp_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .IW         (IW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .position   (position),
        .value      (value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_status (res_status),
        .res_value  (res_value),
        .res_count  (res_count),
        .mem_ctl    (mem_ctl),
        .link_raddr (link_raddr),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .link_q     (link_q),
        .val_raddr  (val_raddr),
        .val_waddr  (val_waddr),
        .val_wdata  (val_wdata),
        .val_q      (val_q)
    );

    plp_store #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .IW         (IW)
    ) u_store (
        .clk        (clk),
        .mem_ctl    (mem_ctl),
        .link_raddr (link_raddr),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .link_q     (link_q),
        .val_raddr  (val_raddr),
        .val_waddr  (val_waddr),
        .val_wdata  (val_wdata),
        .val_q      (val_q)
    );

    // The output register takes a new result when empty or being drained.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            status_reg    <= res_status;
            value_out_reg <= res_value;
            count_reg     <= res_count;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;
    assign count     = count_reg;

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready
    ) else $error("sequencer accepted a second item while busy");

    a_zero_on_fail: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_DONE) |-> (value_out == '0)
    ) else $error("failed operation returned a nonzero value");

    a_count_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(count) <= CAPACITY)
    ) else $error("entry count exceeds store capacity");

    a_full_only_insert_sized: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> (32'(count) >= CAPACITY) || (count == CNT_W'(CAPACITY))
    ) else $error("store full reported below capacity");

endmodule

/* design/plp_store.sv */
// ----------------------------------------------------------------------------
// plp_store
// Node store: a link memory and a value memory, each with one write port and
// one read port whose data is registered.
// ----------------------------------------------------------------------------
module plp_store
    import plp_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = $clog2(CAPACITY),
    parameter int IW         = $clog2(CAPACITY + 1)
)
(
    input  logic                  clk,
    input  plp_mem_ctl_t          mem_ctl,
    input  logic [AW-1:0]         link_raddr,
    input  logic [AW-1:0]         link_waddr,
    input  logic [IW-1:0]         link_wdata,
    output logic [IW-1:0]         link_q,
    input  logic [AW-1:0]         val_raddr,
    input  logic [AW-1:0]         val_waddr,
    input  logic [DATA_WIDTH-1:0] val_wdata,
    output logic [DATA_WIDTH-1:0] val_q
);

    logic [IW-1:0]         link_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] val_mem  [CAPACITY];
    logic [IW-1:0]         link_q_reg;
    logic [DATA_WIDTH-1:0] val_q_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.link_wr)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (mem_ctl.link_rd)
        begin
            link_q_reg <= link_mem[link_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.val_wr)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (mem_ctl.val_rd)
        begin
            val_q_reg <= val_mem[val_raddr];
        end
    end

    assign link_q = link_q_reg;
    assign val_q  = val_q_reg;

endmodule

/* design/plp_ctrl.sv */
// ----------------------------------------------------------------------------
// plp_ctrl
// Sequencer: checks each item, allocates and frees nodes, walks links from
// the head and rewrites links in the node store.
// ----------------------------------------------------------------------------
module plp_ctrl
    import plp_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = $clog2(CAPACITY),
    parameter int IW         = $clog2(CAPACITY + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [FUNC_W-1:0]        func,
    input  logic [POS_W-1:0]         position,
    input  logic signed [VAL_W-1:0]  value,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic [STAT_W-1:0]        res_status,
    output logic [VAL_W-1:0]         res_value,
    output logic [CNT_W-1:0]         res_count,
    output plp_mem_ctl_t             mem_ctl,
    output logic [AW-1:0]            link_raddr,
    output logic [AW-1:0]            link_waddr,
    output logic [IW-1:0]            link_wdata,
    input  logic [IW-1:0]            link_q,
    output logic [AW-1:0]            val_raddr,
    output logic [AW-1:0]            val_waddr,
    output logic [DATA_WIDTH-1:0]    val_wdata,
    input  logic [DATA_WIDTH-1:0]    val_q
);

    localparam int VW   = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;
    localparam int CMPW = ((IW > POS_W) ? IW : POS_W) + 1;
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_CHECK    = 12'b0000_0000_0010,
        S_ALLOC    = 12'b0000_0000_0100,
        S_LINKLAST = 12'b0000_0000_1000,
        S_WSTART   = 12'b0000_0001_0000,
        S_WALK     = 12'b0000_0010_0000,
        S_WEND     = 12'b0000_0100_0000,
        S_LINKPRED = 12'b0000_1000_0000,
        S_DEL      = 12'b0001_0000_0000,
        S_FREE     = 12'b0010_0000_0000,
        S_RVAL     = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } plp_state_t;

    plp_state_t state_reg, state_next;
    logic [IW-1:0] first_reg, first_next;
    logic [IW-1:0] last_reg, last_next;
    logic [IW-1:0] free_reg, free_next;
    logic [IW-1:0] fresh_reg, fresh_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] steps_reg, steps_next;

    logic [FUNC_W-1:0]     func_reg, func_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [IW-1:0]         nn_reg, nn_next;
    logic [IW-1:0]         tgt_reg, tgt_next;
    logic [IW-1:0]         vic_reg, vic_next;
    logic [STAT_W-1:0]     status_reg, status_next;
    logic [VAL_W-1:0]      vout_reg, vout_next;

    logic [IW-1:0] lr_node, lw_node, vr_node, vw_node;
    logic [CMPW-1:0] pos_w, cnt_w;
    logic pos_in_list, pos_for_insert, is_append, store_full;

    assign pos_w          = CMPW'(pos_reg);
    assign cnt_w          = CMPW'(cnt_reg);
    assign pos_in_list    = (pos_reg != '0) && (pos_w <= cnt_w);
    assign pos_for_insert = (pos_reg != '0) && (pos_w <= cnt_w + CMPW'(1));
    assign is_append      = (pos_w == cnt_w + CMPW'(1));
    assign store_full     = (free_reg == NIL) || (cnt_reg == NIL);

    always_comb
    begin
        state_next  = state_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        free_next   = free_reg;
        fresh_next  = fresh_reg;
        cnt_next    = cnt_reg;
        steps_next  = steps_reg;
        func_next   = func_reg;
        pos_next    = pos_reg;
        data_next   = data_reg;
        nn_next     = nn_reg;
        tgt_next    = tgt_reg;
        vic_next    = vic_reg;
        status_next = status_reg;
        vout_next   = vout_reg;
        mem_ctl     = '0;
        lr_node     = first_reg;
        lw_node     = nn_reg;
        link_wdata  = NIL;
        vr_node     = tgt_reg;
        vw_node     = free_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    func_next  = func;
                    pos_next   = position;
                    data_next  = DATA_WIDTH'(value[VW-1:0]);
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                status_next = ST_RANGE;
                vout_next   = '0;
                state_next  = S_DONE;
                case (func_reg)
                    FN_INSERT:
                    begin
                        if (pos_for_insert && store_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (pos_for_insert)
                        begin
                            // Take the free-list head and read its link.
                            status_next    = ST_DONE;
                            mem_ctl.link_rd = 1'b1;
                            lr_node        = free_reg;
                            mem_ctl.val_wr = 1'b1;
                            vw_node        = free_reg;
                            nn_next        = free_reg;
                            steps_next     = pos_reg - POS_W'(2);
                            state_next     = S_ALLOC;
                        end
                    end
                    FN_DELETE:
                    begin
                        if (pos_in_list)
                        begin
                            status_next = ST_DONE;
                            if (pos_reg == POS_W'(1))
                            begin
                                vic_next        = first_reg;
                                mem_ctl.link_rd = 1'b1;
                                lr_node         = first_reg;
                                mem_ctl.val_rd  = 1'b1;
                                vr_node         = first_reg;
                                state_next      = S_DEL;
                            end
                            else
                            begin
                                steps_next = pos_reg - POS_W'(2);
                                state_next = S_WSTART;
                            end
                        end
                    end
                    FN_READ:
                    begin
                        if (pos_in_list)
                        begin
                            status_next = ST_DONE;
                            steps_next  = pos_reg - POS_W'(1);
                            state_next  = S_WSTART;
                        end
                    end
                    default:
                    begin
                        status_next = ST_RANGE;
                    end
                endcase
            end

            S_ALLOC:
            begin
                // Nodes at or above the fill mark were never used and still
                // chain to their successor.
                if (nn_reg == fresh_reg)
                begin
                    free_next  = fresh_reg + IW'(1);
                    fresh_next = fresh_reg + IW'(1);
                end
                else
                begin
                    free_next = link_q;
                end
                if (is_append)
                begin
                    mem_ctl.link_wr = 1'b1;
                    lw_node         = nn_reg;
                    link_wdata      = NIL;
                    if (cnt_reg != '0)
                    begin
                        state_next = S_LINKLAST;
                    end
                    else
                    begin
                        first_next = nn_reg;
                        last_next  = nn_reg;
                        cnt_next   = cnt_reg + IW'(1);
                        state_next = S_DONE;
                    end
                end
                else if (pos_reg == POS_W'(1))
                begin
                    mem_ctl.link_wr = 1'b1;
                    lw_node         = nn_reg;
                    link_wdata      = first_reg;
                    first_next      = nn_reg;
                    cnt_next        = cnt_reg + IW'(1);
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_WSTART;
                end
            end

            S_LINKLAST:
            begin
                mem_ctl.link_wr = 1'b1;
                lw_node         = last_reg;
                link_wdata      = nn_reg;
                last_next       = nn_reg;
                cnt_next        = cnt_reg + IW'(1);
                state_next      = S_DONE;
            end

            S_WSTART:
            begin
                tgt_next        = first_reg;
                mem_ctl.link_rd = 1'b1;
                lr_node         = first_reg;
                state_next      = (steps_reg == '0) ? S_WEND : S_WALK;
            end

            S_WALK:
            begin
                // One hop per cycle: the read data addresses the next read.
                tgt_next        = link_q;
                mem_ctl.link_rd = 1'b1;
                lr_node         = link_q;
                steps_next      = steps_reg - POS_W'(1);
                if (steps_reg == POS_W'(1))
                begin
                    state_next = S_WEND;
                end
            end

            S_WEND:
            begin
                case (func_reg)
                    FN_INSERT:
                    begin
                        mem_ctl.link_wr = 1'b1;
                        lw_node         = nn_reg;
                        link_wdata      = link_q;
                        state_next      = S_LINKPRED;
                    end
                    FN_DELETE:
                    begin
                        vic_next        = link_q;
                        mem_ctl.link_rd = 1'b1;
                        lr_node         = link_q;
                        mem_ctl.val_rd  = 1'b1;
                        vr_node         = link_q;
                        state_next      = S_DEL;
                    end
                    default:
                    begin
                        mem_ctl.val_rd = 1'b1;
                        vr_node        = tgt_reg;
                        state_next     = S_RVAL;
                    end
                endcase
            end

            S_LINKPRED:
            begin
                mem_ctl.link_wr = 1'b1;
                lw_node         = tgt_reg;
                link_wdata      = nn_reg;
                cnt_next        = cnt_reg + IW'(1);
                state_next      = S_DONE;
            end

            S_DEL:
            begin
                vout_next = VAL_W'(val_q[VW-1:0]);
                if (pos_reg == POS_W'(1))
                begin
                    first_next = link_q;
                end
                else
                begin
                    mem_ctl.link_wr = 1'b1;
                    lw_node         = tgt_reg;
                    link_wdata      = link_q;
                end
                // Removing the tail moves the tail back to the predecessor.
                if (vic_reg == last_reg)
                begin
                    last_next = (pos_reg == POS_W'(1)) ? NIL : tgt_reg;
                end
                state_next = S_FREE;
            end

            S_FREE:
            begin
                mem_ctl.link_wr = 1'b1;
                lw_node         = vic_reg;
                link_wdata      = free_reg;
                free_next       = vic_reg;
                cnt_next        = cnt_reg - IW'(1);
                if (cnt_reg == IW'(1))
                begin
                    first_next = NIL;
                    last_next  = NIL;
                end
                state_next = S_DONE;
            end

            S_RVAL:
            begin
                vout_next  = VAL_W'(val_q[VW-1:0]);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign link_raddr = lr_node[AW-1:0];
    assign link_waddr = lw_node[AW-1:0];
    assign val_raddr  = vr_node[AW-1:0];
    assign val_waddr  = vw_node[AW-1:0];
    assign val_wdata  = data_reg;
    assign res_status = status_reg;
    assign res_value  = vout_reg;
    assign res_count  = CNT_W'(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= NIL;
            last_reg  <= NIL;
            free_reg  <= '0;
            fresh_reg <= '0;
            cnt_reg   <= '0;
            steps_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            free_reg  <= free_next;
            fresh_reg <= fresh_next;
            cnt_reg   <= cnt_next;
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        pos_reg    <= pos_next;
        data_reg   <= data_next;
        nn_reg     <= nn_next;
        tgt_reg    <= tgt_next;
        vic_reg    <= vic_next;
        status_reg <= status_next;
        vout_reg   <= vout_next;
    end

endmodule

/* tb/sv/plp_list_checker.sv */
// ----------------------------------------------------------------------------
// plp_list_checker
// Watches both channels of the positional linked list, keeps its own copy of
// the list as a queue of values, predicts each result and compares it field
// by field with what the block returns.
// ----------------------------------------------------------------------------
module plp_list_checker
    import plp_pkg::*;
#(
    parameter int LIST_DEPTH = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [FUNC_W-1:0]       func,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [STAT_W-1:0]       status,
    input  logic signed [VAL_W-1:0] value_out,
    input  logic [CNT_W-1:0]        count,
    output int                      fail_count,
    output int                      pending_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STAT_W-1:0]       st;
        logic signed [VAL_W-1:0] val;
        logic [CNT_W-1:0]        cnt;
    } list_result_t;

    logic signed [VAL_W-1:0] list_vals[$];
    list_result_t            pending_results[$];
    int                      errors = 0;

    // Applies one operation to the shadow list and returns what the block
    // should answer.
    function automatic list_result_t list_apply(input logic [FUNC_W-1:0] f,
                                                input logic [POS_W-1:0] p,
                                                input logic signed [VAL_W-1:0] v);
        list_result_t r;
        int           n;
        int           pi;
        n     = list_vals.size();
        pi    = int'(p);
        r.st  = ST_RANGE;
        r.val = '0;
        case (f)
            FN_INSERT:
            begin
                // The position is checked before the store is found full.
                if (pi >= 1 && pi <= n + 1)
                begin
                    if (n >= LIST_DEPTH)
                        r.st = ST_FULL;
                    else
                    begin
                        // Position n + 1 lands after the last entry.
                        list_vals.insert(pi - 1, v);
                        r.st = ST_DONE;
                    end
                end
            end
            FN_DELETE:
            begin
                if (pi >= 1 && pi <= n)
                begin
                    r.val = list_vals[pi - 1];
                    list_vals.delete(pi - 1);
                    r.st = ST_DONE;
                end
            end
            FN_READ:
            begin
                if (pi >= 1 && pi <= n)
                begin
                    r.val = list_vals[pi - 1];
                    r.st  = ST_DONE;
                end
            end
            default:
                r.st = ST_RANGE;
        endcase
        r.cnt = CNT_W'(list_vals.size());
        return r;
    endfunction

    always @(posedge clk)
    begin
        list_result_t exp_r;
        bit           bad;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with nothing pending: status %0d value %0d count %0d",
                             $time, status, value_out, count);
                    errors = errors + 1;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    bad   = 1'b0;
                    if (status !== exp_r.st)
                    begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, exp_r.st, status);
                        bad = 1'b1;
                    end
                    if (value_out !== exp_r.val)
                    begin
                        $display("%0t: value_out mismatch: expected %0d actual %0d",
                                 $time, exp_r.val, value_out);
                        bad = 1'b1;
                    end
                    if (count !== exp_r.cnt)
                    begin
                        $display("%0t: count mismatch: expected %0d actual %0d",
                                 $time, exp_r.cnt, count);
                        bad = 1'b1;
                    end
                    if (bad)
                        errors = errors + 1;
                end
            end
            if (in_valid && in_ready)
                pending_results.insert(pending_results.size(),
                                       list_apply(func, position, value));
        end
        fail_count    <= errors;
        pending_count <= pending_results.size();
    end

endmodule

/* tb/sv/positional_linked_list_tb.sv */
// ----------------------------------------------------------------------------
// positional_linked_list_tb
// Drives insert, delete and read items into the positional linked list with
// random gaps and output stalls. A short directed run covers empty-list
// errors, head, middle and tail updates and tail repair after deleting the
// last entry; the random run then fills the store to full and drains it
// again several times, with some malformed items mixed in.
// ----------------------------------------------------------------------------
module positional_linked_list_tb
    import plp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                LIST_DEPTH   = 64;
    localparam int                RANDOM_ITEMS = 1550;
    localparam int                DRAIN_CYCLES = 100;
    localparam int                CYCLE_LIMIT  = 1200000;
    localparam logic [FUNC_W-1:0] FN_UNUSED    = 2'd3;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic [FUNC_W-1:0]       func      = FN_READ;
    logic [POS_W-1:0]        position  = '0;
    logic signed [VAL_W-1:0] value     = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] value_out;
    logic [CNT_W-1:0]        count;

    int fail_count;
    int pending_count;
    int cycles     = 0;
    int hold_left  = 0;
    bit in_calm    = 1'b0;
    bit out_calm   = 1'b0;
    int shadow_len = 0;

    positional_linked_list dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .position  (position),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .value_out (value_out),
        .count     (count)
    );

    plp_list_checker #(.LIST_DEPTH(LIST_DEPTH)) u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .position      (position),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .value_out     (value_out),
        .count         (count),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Mostly short pauses, a few long ones, none at all in calm stretches.
    function automatic int pick_pause(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        int s;
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                out_calm <= !out_calm;
            s = pick_pause(out_calm);
            out_ready <= (s == 0);
            hold_left <= (s > 0) ? s - 1 : 0;
        end
    end

    // Presents one item and returns at the edge where it is accepted. Valid
    // stays high from the previous item when no gap is chosen.
    task automatic issue_op(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                            input logic signed [VAL_W-1:0] v);
        int gap;
        bit rdy;
        if ($urandom_range(0, 39) == 0)
            in_calm = !in_calm;
        gap = pick_pause(in_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        position <= p;
        value    <= v;
        do
        begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end
        while (!rdy);
        // Track the list length so that positions can be aimed at it.
        if (f == FN_INSERT && p >= 1 && p <= shadow_len + 1 && shadow_len < LIST_DEPTH)
            shadow_len = shadow_len + 1;
        else if (f == FN_DELETE && p >= 1 && p <= shadow_len)
            shadow_len = shadow_len - 1;
    endtask

    function automatic logic [POS_W-1:0] pick_position(input logic [FUNC_W-1:0] f,
                                                        input int len);
        int top_pos;
        int r;
        top_pos = (f == FN_INSERT) ? len + 1 : len;
        if (top_pos < 1)
            return POS_W'($urandom_range(0, 2));
        r = $urandom_range(0, 9);
        if (r < 2)
            return POS_W'(1);
        if (r < 4)
            return POS_W'(top_pos);
        return POS_W'($urandom_range(1, top_pos));
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return VAL_MAX;
        if (r == 1)
            return VAL_MIN;
        if (r == 2)
            return '0;
        if (r == 3)
            return -1;
        return $urandom;
    endfunction

    initial
    begin
        logic [FUNC_W-1:0]       f;
        logic [POS_W-1:0]        p;
        logic signed [VAL_W-1:0] v;
        int                      roll;
        bit                      filling;
        int                      full_tries;
        filling    = 1'b1;
        full_tries = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Errors on an empty list.
        issue_op(FN_READ,   7'd1, pick_value());
        issue_op(FN_DELETE, 7'd1, pick_value());
        issue_op(FN_INSERT, 7'd0, pick_value());
        issue_op(FN_INSERT, 7'd2, pick_value());
        // Build the list through the tail, the head and the middle.
        issue_op(FN_INSERT, 7'd1, VAL_MAX);
        issue_op(FN_INSERT, 7'd2, VAL_MIN);
        issue_op(FN_INSERT, 7'd1, '0);
        issue_op(FN_INSERT, 7'd2, -1);
        issue_op(FN_READ,   7'd4, pick_value());
        issue_op(FN_READ,   7'd5, pick_value());
        issue_op(FN_UNUSED, 7'd1, pick_value());
        issue_op(FN_INSERT, 7'd6, pick_value());
        // Removing the last entry must move the tail so an append still links.
        issue_op(FN_DELETE, 7'd4, pick_value());
        issue_op(FN_INSERT, 7'd4, 32'sh5A5A_A5A5);
        issue_op(FN_READ,   7'd4, pick_value());
        issue_op(FN_DELETE, 7'd1, pick_value());
        issue_op(FN_DELETE, 7'd2, pick_value());
        issue_op(FN_READ,   7'd127, pick_value());
        issue_op(FN_READ,   7'd64, pick_value());
        issue_op(FN_DELETE, 7'd2, pick_value());
        issue_op(FN_DELETE, 7'd1, pick_value());
        // Append to a list that was emptied by deletes.
        issue_op(FN_INSERT, 7'd1, 32'sh1234_5678);
        issue_op(FN_READ,   7'd1, pick_value());
        issue_op(FN_DELETE, 7'd1, pick_value());

        // Random part: alternate between filling to full and draining to empty.
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                f = FUNC_W'($urandom_range(0, 3));
                p = POS_W'($urandom_range(0, 127));
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (filling)
                    f = (roll < 65) ? FN_INSERT : (roll < 80) ? FN_DELETE : FN_READ;
                else
                    f = (roll < 15) ? FN_INSERT : (roll < 80) ? FN_DELETE : FN_READ;
                p = pick_position(f, shadow_len);
            end
            v = pick_value();
            if (shadow_len == LIST_DEPTH && f == FN_INSERT)
                full_tries = full_tries + 1;
            issue_op(f, p, v);
            if (filling && full_tries >= 3)
            begin
                filling    = 1'b0;
                full_tries = 0;
            end
            else if (!filling && shadow_len == 0)
                filling = 1'b1;
        end
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
